>>> rtl/flba_pkg.sv
// flba_pkg: shared types, codes and constants of the free-list block allocator.
// No dependencies; used by every module of the block and by its checker.
package flba_pkg;

  localparam int unsigned MaxBlocksDef     = 256;
  localparam int unsigned MaxBlockBytesDef = 4096;

  localparam int unsigned OfsW     = 20;
  localparam int unsigned PoolW    = 9;
  localparam int unsigned BytesW   = 13;
  localparam int unsigned CntOutW  = 9;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 13;

  localparam int unsigned PoolBlocksRst = 256;
  localparam int unsigned BlockBytesRst = 64;

  // radix-2 restoring divider, DivStep quotient bits per cycle
  localparam int unsigned DivStep   = 4;
  localparam int unsigned DivCycles = (OfsW + DivStep - 1) / DivStep;
  localparam int unsigned DivCntW   = $clog2(DivCycles);

  localparam logic [CfgIdxW-1:0] CfgPoolBlocks = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgBlockBytes = 4'd1;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REINIT = 2'd2,
    OP_IGNORE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_OFS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_PUSH = 2'd1,
    SH_POP  = 2'd2
  } shift_e;

  typedef struct packed {
    logic              start;
    logic [OfsW-1:0]   dividend;
    logic [BytesW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [OfsW-1:0]   quotient;
    logic [BytesW-1:0] remainder;
  } div_rsp_t;

endpackage

>>> rtl/flba_cell.sv
// flba_cell: one entry of the shifting free stack.
// Depends on flba_pkg (shift_e, OfsW).
module flba_cell (
  input  logic                      clk_i,
  input  flba_pkg::shift_e          cmd_i,
  input  logic [flba_pkg::OfsW-1:0] upper_i,
  input  logic [flba_pkg::OfsW-1:0] lower_i,
  output logic [flba_pkg::OfsW-1:0] data_o
);

  logic [flba_pkg::OfsW-1:0] data_q, data_d;

  always_comb begin
    unique case (cmd_i)
      flba_pkg::SH_PUSH: data_d = upper_i;
      flba_pkg::SH_POP:  data_d = lower_i;
      default:           data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> rtl/flba_div.sv
// flba_div: multi-cycle restoring divider for the free offset check.
// Depends on flba_pkg (div_req_t, div_rsp_t, DivStep, DivCycles).
module flba_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  flba_pkg::div_req_t req_i,
  output flba_pkg::div_rsp_t rsp_o
);

  logic                                busy_q, done_q;
  logic [flba_pkg::DivCntW-1:0]        cnt_q;
  logic [flba_pkg::BytesW-1:0]         rem_q, rem_d, dsr_q;
  logic [flba_pkg::OfsW-1:0]           quo_q, quo_d;

  always_comb begin
    logic [flba_pkg::BytesW:0] t;
    rem_d = rem_q;
    quo_d = quo_q;
    t     = '0;
    for (int s = 0; s < int'(flba_pkg::DivStep); s++) begin
      t     = {rem_d, quo_d[flba_pkg::OfsW-1]};
      quo_d = {quo_d[flba_pkg::OfsW-2:0], 1'b0};
      if (t >= {1'b0, dsr_q}) begin
        rem_d    = flba_pkg::BytesW'(t - {1'b0, dsr_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = t[flba_pkg::BytesW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + flba_pkg::DivCntW'(1);
        if (cnt_q == flba_pkg::DivCntW'(flba_pkg::DivCycles - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> rtl/free_list_block_allocator_unit.sv
// free_list_block_allocator_unit: LIFO free-list block allocator, top level.
// Depends on flba_pkg, flba_cell (stack row) and flba_div (offset check).
//
// Usage:
//   Input channel (in_valid_i/in_stall_o) carries one item: op_i and
//   block_offset_in_i. Each item yields exactly one result item on the
//   output channel (out_valid_o/out_stall_i): offset, status, free count.
//   Config port (cfg_valid_i/cfg_ready_o) writes pool_blocks (index 0) or
//   block_bytes (index 1); it is always ready, other indexes are dropped.
//   The free stack is a row of MAX_BLOCKS cells, top of stack in cell 0;
//   push and pop shift the whole row by one cell at once.
// Steps (accept to result):
//   allocate / ignored op: S_IDLE, then S_DONE loads the result register.
//   free: S_IDLE, then S_DIV while the divider checks the offset
//     (4 quotient bits per cycle), then S_DONE.
//   reinitialize: S_FILL does one cell push per block of the pool, then S_DONE.
//   One item is in work at a time; a new item is taken while the last
//   result still waits in the output register.
// Reset: the stack refills with the reset configuration, pushing
//   min(256, MAX_BLOCKS) blocks with in_stall_o high; no result is made.
// Output stall: the result register holds; a finished item waits for it.
module free_list_block_allocator_unit #(
  parameter int unsigned MAX_BLOCKS      = flba_pkg::MaxBlocksDef,
  parameter int unsigned MAX_BLOCK_BYTES = flba_pkg::MaxBlockBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [flba_pkg::OfsW-1:0]     block_offset_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [flba_pkg::OfsW-1:0]     block_offset_out_o,
  output logic [1:0]                    status_o,
  output logic [flba_pkg::CntOutW-1:0]  free_blocks_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [flba_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [flba_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CntW     = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned RstPool  = (flba_pkg::PoolBlocksRst > MAX_BLOCKS) ?
                                     MAX_BLOCKS : flba_pkg::PoolBlocksRst;
  localparam int unsigned RstBytes = (flba_pkg::BlockBytesRst > MAX_BLOCK_BYTES) ?
                                     MAX_BLOCK_BYTES : flba_pkg::BlockBytesRst;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_FILL = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  flba_pkg::op_e                 op_q, op_d;
  logic [flba_pkg::OfsW-1:0]     ofs_q, ofs_d;
  logic                          bad_q, bad_d;
  logic [CntW-1:0]               count_q, count_d;
  logic [CntW-1:0]               fill_left_q, fill_left_d;
  logic [flba_pkg::OfsW-1:0]     fill_val_q, fill_val_d;
  logic [flba_pkg::BytesW-1:0]   fill_b_q, fill_b_d;
  logic                          fill_post_q, fill_post_d;
  logic [flba_pkg::PoolW-1:0]    pool_blocks_q;
  logic [flba_pkg::BytesW-1:0]   block_bytes_q;
  logic                          out_valid_q, out_valid_d;
  logic [flba_pkg::OfsW-1:0]     out_ofs_q, out_ofs_d;
  flba_pkg::status_e             out_status_q, out_status_d;
  logic [flba_pkg::CntOutW-1:0]  out_free_q, out_free_d;

  logic [CntW-1:0]               eff_pool;
  logic [flba_pkg::BytesW-1:0]   eff_bytes;
  logic                          slot_free;
  flba_pkg::shift_e              shift_cmd;
  logic [flba_pkg::OfsW-1:0]     push_data;
  logic [flba_pkg::OfsW-1:0]     cell_data [MAX_BLOCKS];
  flba_pkg::div_req_t            div_req;
  flba_pkg::div_rsp_t            div_rsp;

  always_comb begin
    if (32'(pool_blocks_q) > MAX_BLOCKS) eff_pool = CntW'(MAX_BLOCKS);
    else                                 eff_pool = CntW'(pool_blocks_q);
  end

  always_comb begin
    if (block_bytes_q == '0) begin
      eff_bytes = flba_pkg::BytesW'(1);
    end else if (32'(block_bytes_q) > MAX_BLOCK_BYTES) begin
      eff_bytes = flba_pkg::BytesW'(MAX_BLOCK_BYTES);
    end else begin
      eff_bytes = block_bytes_q;
    end
  end

  // stack row
  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    logic [flba_pkg::OfsW-1:0] upper, lower;
    if (k == 0) begin : g_top
      assign upper = push_data;
    end else begin : g_mid
      assign upper = cell_data[k-1];
    end
    if (k == MAX_BLOCKS - 1) begin : g_bot
      assign lower = '0;
    end else begin : g_up
      assign lower = cell_data[k+1];
    end
    flba_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (shift_cmd),
      .upper_i (upper),
      .lower_i (lower),
      .data_o  (cell_data[k])
    );
  end

  flba_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    ofs_d        = ofs_q;
    bad_d        = bad_q;
    count_d      = count_q;
    fill_left_d  = fill_left_q;
    fill_val_d   = fill_val_q;
    fill_b_d     = fill_b_q;
    fill_post_d  = fill_post_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_ofs_d    = out_ofs_q;
    out_status_d = out_status_q;
    out_free_d   = out_free_q;
    shift_cmd    = flba_pkg::SH_HOLD;
    push_data    = ofs_q;
    in_stall_o   = 1'b1;
    div_req.start    = 1'b0;
    div_req.dividend = block_offset_in_i;
    div_req.divisor  = eff_bytes;

    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d  = flba_pkg::op_e'(op_i);
          ofs_d = block_offset_in_i;
          unique case (flba_pkg::op_e'(op_i))
            flba_pkg::OP_FREE: begin
              div_req.start = 1'b1;
              state_d       = S_DIV;
            end
            flba_pkg::OP_REINIT: begin
              fill_left_d = eff_pool;
              fill_val_d  = '0;
              fill_b_d    = eff_bytes;
              fill_post_d = 1'b1;
              count_d     = '0;
              state_d     = S_FILL;
            end
            flba_pkg::OP_ALLOC:  state_d = S_DONE;
            flba_pkg::OP_IGNORE: state_d = S_DONE;
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          bad_d   = (32'(div_rsp.quotient) >= 32'(eff_pool)) || (div_rsp.remainder != '0);
          state_d = S_DONE;
        end
      end
      S_FILL: begin
        push_data = fill_val_q;
        if (fill_left_q == '0) begin
          fill_post_d = 1'b0;
          state_d     = fill_post_q ? S_DONE : S_IDLE;
        end else begin
          shift_cmd   = flba_pkg::SH_PUSH;
          fill_val_d  = fill_val_q + flba_pkg::OfsW'(fill_b_q);
          fill_left_d = fill_left_q - CntW'(1);
          count_d     = count_q + CntW'(1);
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_ofs_d    = '0;
          out_status_d = flba_pkg::ST_OK;
          state_d      = S_IDLE;
          unique case (op_q)
            flba_pkg::OP_ALLOC: begin
              if (count_q == '0) begin
                out_status_d = flba_pkg::ST_EMPTY;
              end else begin
                shift_cmd = flba_pkg::SH_POP;
                count_d   = count_q - CntW'(1);
                out_ofs_d = cell_data[0];
              end
            end
            flba_pkg::OP_FREE: begin
              priority if (bad_q) begin
                out_status_d = flba_pkg::ST_BAD_OFS;
              end else if (count_q >= eff_pool) begin
                out_status_d = flba_pkg::ST_FULL;
              end else begin
                shift_cmd = flba_pkg::SH_PUSH;
                count_d   = count_q + CntW'(1);
              end
            end
            flba_pkg::OP_REINIT: ;
            flba_pkg::OP_IGNORE: ;
          endcase
          out_free_d = flba_pkg::CntOutW'(32'(count_d));
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_FILL;
      op_q          <= flba_pkg::OP_IGNORE;
      bad_q         <= 1'b0;
      count_q       <= '0;
      fill_left_q   <= CntW'(RstPool);
      fill_val_q    <= '0;
      fill_b_q      <= flba_pkg::BytesW'(RstBytes);
      fill_post_q   <= 1'b0;
      pool_blocks_q <= flba_pkg::PoolW'(flba_pkg::PoolBlocksRst);
      block_bytes_q <= flba_pkg::BytesW'(flba_pkg::BlockBytesRst);
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      bad_q       <= bad_d;
      count_q     <= count_d;
      fill_left_q <= fill_left_d;
      fill_val_q  <= fill_val_d;
      fill_b_q    <= fill_b_d;
      fill_post_q <= fill_post_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == flba_pkg::CfgPoolBlocks) begin
          pool_blocks_q <= cfg_data_i[flba_pkg::PoolW-1:0];
        end else if (cfg_index_i == flba_pkg::CfgBlockBytes) begin
          block_bytes_q <= cfg_data_i[flba_pkg::BytesW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ofs_q        <= ofs_d;
    out_ofs_q    <= out_ofs_d;
    out_status_q <= out_status_d;
    out_free_q   <= out_free_d;
  end

  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign block_offset_out_o = out_ofs_q;
  assign status_o           = out_status_q;
  assign free_blocks_o      = out_free_q;

endmodule

>>> rtl/flba_chk.sv
// flba_chk: port-level checker for free_list_block_allocator_unit, bound to it.
// Depends on flba_pkg (status codes, field widths).
module flba_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [flba_pkg::OfsW-1:0]     block_offset_out_o,
  input logic [1:0]                    status_o,
  input logic [flba_pkg::CntOutW-1:0]  free_blocks_o
);

  // one item in work: an accepted item blocks the next one
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted back to back");

  a_fail_no_ofs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != flba_pkg::ST_OK |-> block_offset_out_o == '0)
    else $error("failed item carries an offset");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == flba_pkg::ST_EMPTY |-> free_blocks_o == '0)
    else $error("pool empty with free blocks left");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(block_offset_out_o) && $stable(status_o) &&
      $stable(free_blocks_o))
    else $error("stalled result changed");

endmodule

bind free_list_block_allocator_unit flba_chk u_flba_chk (.*);
